>>> src/m61_pkg.sv
// types, constants and the control store for the mod 2^61-1 arithmetic unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package m61_pkg;

    localparam int M61_BITS = 61;
    localparam logic [60:0] M61_P = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [60:0] M61_EXP = M61_P - 61'd2;
    localparam logic [5:0] M61_CNT_LAST = 6'(M61_BITS - 1);

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_NEG = 3'd3;
    localparam logic [2:0] MODE_INV = 3'd4;
    localparam logic [2:0] MODE_RED = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] operand_a;
        logic [60:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [60:0] result;
        logic        error;
    } t_out_item;

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE     = 4'd0;
    localparam t_step S_LOAD     = 4'd1;
    localparam t_step S_ADD      = 4'd2;
    localparam t_step S_SUB      = 4'd3;
    localparam t_step S_NEG      = 4'd4;
    localparam t_step S_RED      = 4'd5;
    localparam t_step S_BAD      = 4'd6;
    localparam t_step S_MUL      = 4'd7;
    localparam t_step S_INV      = 4'd8;
    localparam t_step S_INV_TEST = 4'd9;
    localparam t_step S_INV_MUL  = 4'd10;
    localparam t_step S_INV_SQR  = 4'd11;
    localparam t_step S_INV_STEP = 4'd12;
    localparam t_step S_EMIT     = 4'd13;
    localparam t_step S_ZERR     = 4'd14;
    localparam t_step S_SPARE    = 4'd15;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_RED,
        OP_CLR,
        OP_ZERR,
        OP_INIT,
        OP_INC,
        OP_MUL_AB,
        OP_MUL_RB,
        OP_MUL_BB
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_ACCEPT,
        C_DISPATCH,
        C_AZERO,
        C_MULW,
        C_EBIT0,
        C_LOOP,
        C_EMIT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic       in_valid;
        logic       out_free;
        logic       a_zero;
        logic       ebit;
        logic       cnt_last;
        logic       mul_done;
        logic [2:0] mode;
    } t_status;

    typedef struct packed {
        t_op  op;
        logic in_ready;
        logic emit;
    } t_ctl;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PROD,
        M_FOLD,
        M_FOLD2,
        M_FIN,
        M_DONE
    } t_mul_state;

    function automatic t_uword m61_urom(input t_step s);
        t_uword w;
        unique case (s)
            S_IDLE:     w = '{OP_NOP,    C_ACCEPT,   S_IDLE};
            S_LOAD:     w = '{OP_LOAD,   C_DISPATCH, S_IDLE};
            S_ADD:      w = '{OP_ADD,    C_JUMP,     S_EMIT};
            S_SUB:      w = '{OP_SUB,    C_JUMP,     S_EMIT};
            S_NEG:      w = '{OP_NEG,    C_JUMP,     S_EMIT};
            S_RED:      w = '{OP_RED,    C_JUMP,     S_EMIT};
            S_BAD:      w = '{OP_CLR,    C_JUMP,     S_EMIT};
            S_MUL:      w = '{OP_MUL_AB, C_MULW,     S_EMIT};
            S_INV:      w = '{OP_INIT,   C_AZERO,    S_ZERR};
            S_INV_TEST: w = '{OP_NOP,    C_EBIT0,    S_INV_SQR};
            S_INV_MUL:  w = '{OP_MUL_RB, C_MULW,     S_INV_SQR};
            S_INV_SQR:  w = '{OP_MUL_BB, C_MULW,     S_INV_STEP};
            S_INV_STEP: w = '{OP_INC,    C_LOOP,     S_INV_TEST};
            S_EMIT:     w = '{OP_NOP,    C_EMIT,     S_IDLE};
            S_ZERR:     w = '{OP_ZERR,   C_JUMP,     S_EMIT};
            S_SPARE:    w = '{OP_NOP,    C_JUMP,     S_IDLE};
        endcase
        return w;
    endfunction

    function automatic t_step m61_dispatch(input logic [2:0] mode);
        t_step s;
        unique case (mode)
            MODE_ADD: s = S_ADD;
            MODE_SUB: s = S_SUB;
            MODE_MUL: s = S_MUL;
            MODE_NEG: s = S_NEG;
            MODE_INV: s = S_INV;
            MODE_RED: s = S_RED;
            default:  s = S_BAD;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/m61_mul.sv
// multi-cycle modular multiplier mod 2^61-1 built around one 32x32 multiplier
// depends on m61_pkg
`timescale 1ns / 1ps
`default_nettype none

module m61_mul import m61_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [60:0] i_x,
    input  wire logic [60:0] i_y,
    output logic             o_done,
    output logic [60:0]      o_res
);

    t_mul_state r_state, n_state;

    logic [60:0]  r_x, r_y;
    logic [2:0]   r_k;
    logic [63:0]  r_pp;
    logic [121:0] r_acc;
    logic [61:0]  r_fold;
    logic [60:0]  r_res;

    logic [31:0]  n_opx, n_opy;
    logic [63:0]  n_prod;
    logic [1:0]   n_j;
    logic [121:0] n_shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_state = M_PROD;
                end
            end
            M_PROD: begin
                if (r_k == 3'd4) begin
                    n_state = M_FOLD;
                end
            end
            M_FOLD:  n_state = M_FOLD2;
            M_FOLD2: n_state = M_FIN;
            M_FIN:   n_state = M_DONE;
            M_DONE: begin
                o_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    // partial product select
    always_comb begin
        unique case (r_k[1:0])
            2'd0: begin
                n_opx = r_x[31:0];
                n_opy = r_y[31:0];
            end
            2'd1: begin
                n_opx = r_x[31:0];
                n_opy = {3'd0, r_y[60:32]};
            end
            2'd2: begin
                n_opx = {3'd0, r_x[60:32]};
                n_opy = r_y[31:0];
            end
            default: begin
                n_opx = {3'd0, r_x[60:32]};
                n_opy = {3'd0, r_y[60:32]};
            end
        endcase
        n_prod = n_opx * n_opy;
        n_j    = 2'(r_k - 3'd1);
        unique case (n_j)
            2'd0:    n_shifted = {58'd0, r_pp};
            2'd1,
            2'd2:    n_shifted = {26'd0, r_pp, 32'd0};
            default: n_shifted = {r_pp[57:0], 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                r_x   <= i_x;
                r_y   <= i_y;
                r_k   <= 3'd0;
                r_acc <= '0;
            end
            M_PROD: begin
                if (r_k != 3'd4) begin
                    r_pp <= n_prod;
                end
                if (r_k != 3'd0) begin
                    r_acc <= r_acc + n_shifted;
                end
                r_k <= r_k + 3'd1;
            end
            M_FOLD: begin
                r_fold <= {1'b0, r_acc[60:0]} + {1'b0, r_acc[121:61]};
            end
            M_FOLD2: begin
                r_fold <= {1'b0, r_fold[60:0]} + {61'd0, r_fold[61]};
            end
            M_FIN: begin
                if (r_fold >= {1'b0, M61_P}) begin
                    r_res <= 61'(r_fold - {1'b0, M61_P});
                end else begin
                    r_res <= r_fold[60:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> src/m61_seq.sv
// microcode sequencer: step counter, control store lookup and jump conditions
// depends on m61_pkg
`timescale 1ns / 1ps
`default_nettype none

module m61_seq import m61_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_ctl         o_ctl
);

    t_step  r_step, n_step;
    t_uword n_word;
    t_step  n_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        n_word = m61_urom(r_step);
        n_inc  = r_step + 4'd1;
        n_step = r_step;
        unique case (n_word.cond)
            C_NEXT:     n_step = n_inc;
            C_JUMP:     n_step = n_word.target;
            C_ACCEPT:   n_step = i_status.in_valid ? n_inc : r_step;
            C_DISPATCH: n_step = m61_dispatch(i_status.mode);
            C_AZERO:    n_step = i_status.a_zero ? n_word.target : n_inc;
            C_MULW:     n_step = i_status.mul_done ? n_word.target : r_step;
            C_EBIT0:    n_step = i_status.ebit ? n_inc : n_word.target;
            C_LOOP:     n_step = i_status.cnt_last ? n_inc : n_word.target;
            C_EMIT:     n_step = i_status.out_free ? n_word.target : r_step;
            default:    n_step = S_IDLE;
        endcase
        o_ctl.op       = n_word.op;
        o_ctl.in_ready = (n_word.cond == C_ACCEPT);
        o_ctl.emit     = (n_word.cond == C_EMIT) && i_status.out_free;
    end

endmodule

`default_nettype wire

>>> src/mersenne61_field_alu.sv
// top level of the mod 2^61-1 arithmetic unit: operand and result datapath
// depends on m61_pkg, m61_seq, m61_mul
//
//  port group   | direction | transfer when
//  -------------+-----------+-------------------------------
//  i_in_data    | in        | i_in_valid && !o_in_stall
//  o_out_data   | out       | o_out_valid && !i_out_stall
//
// add, subtract, negate, reduce and unused modes pass through load, their own
// operation step and emit. multiply waits on four partial products
// through the one 32x32 multiplier plus fold and final subtract.
// invert: 121 modular multiplies; a zero operand goes straight to the error result.
// one item at a time; a new item is taken while the last result still waits.
// synchronous active-low reset clears the step counter and handshake state.
`timescale 1ns / 1ps
`default_nettype none

module mersenne61_field_alu import m61_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    t_ctl    ctl;
    t_status status;

    logic [63:0] r_raw;
    logic [60:0] r_braw;
    logic [2:0]  r_mode;
    logic [60:0] r_a, r_b, r_res, r_base;
    logic [5:0]  r_cnt;
    logic        r_err;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        mul_start, mul_done;
    logic [60:0] mul_x, mul_y, mul_res;

    logic [61:0] n_fold, n_sum;
    logic [60:0] n_a, n_b, n_add, n_sub, n_neg;
    logic        n_out_free;

    m61_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    m61_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    assign n_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        status.in_valid = i_in_valid;
        status.out_free = n_out_free;
        status.a_zero   = (r_a == 61'd0);
        status.ebit     = M61_EXP[r_cnt];
        status.cnt_last = (r_cnt == M61_CNT_LAST);
        status.mul_done = mul_done;
        status.mode     = r_mode;
    end

    // operand reduction and the combinational field ops
    always_comb begin
        n_fold = {1'b0, r_raw[60:0]} + {59'd0, r_raw[63:61]};
        if (n_fold >= {1'b0, M61_P}) begin
            n_a = 61'(n_fold - {1'b0, M61_P});
        end else begin
            n_a = n_fold[60:0];
        end
        n_b = (r_braw == M61_P) ? 61'd0 : r_braw;

        n_sum = {1'b0, r_a} + {1'b0, r_b};
        if (n_sum >= {1'b0, M61_P}) begin
            n_add = 61'(n_sum - {1'b0, M61_P});
        end else begin
            n_add = n_sum[60:0];
        end

        if (r_a >= r_b) begin
            n_sub = r_a - r_b;
        end else begin
            n_sub = 61'({1'b0, r_a} + {1'b0, M61_P} - {1'b0, r_b});
        end

        n_neg = (r_a == 61'd0) ? 61'd0 : (M61_P - r_a);
    end

    always_comb begin
        mul_start = 1'b0;
        mul_x     = r_a;
        mul_y     = r_b;
        unique case (ctl.op)
            OP_MUL_AB: begin
                mul_start = 1'b1;
            end
            OP_MUL_RB: begin
                mul_start = 1'b1;
                mul_x     = r_res;
                mul_y     = r_base;
            end
            OP_MUL_BB: begin
                mul_start = 1'b1;
                mul_x     = r_base;
                mul_y     = r_base;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.in_ready && i_in_valid) begin
            r_raw  <= i_in_data.operand_a;
            r_braw <= i_in_data.operand_b;
            r_mode <= i_in_data.mode;
        end
        unique case (ctl.op)
            OP_LOAD: begin
                r_a   <= n_a;
                r_b   <= n_b;
                r_err <= 1'b0;
            end
            OP_ADD:  r_res <= n_add;
            OP_SUB:  r_res <= n_sub;
            OP_NEG:  r_res <= n_neg;
            OP_RED:  r_res <= r_a;
            OP_CLR: begin
                r_res <= 61'd0;
                r_err <= 1'b0;
            end
            OP_ZERR: begin
                r_res <= 61'd0;
                r_err <= 1'b1;
            end
            OP_INIT: begin
                r_res  <= 61'd1;
                r_base <= r_a;
                r_cnt  <= 6'd0;
            end
            OP_INC: r_cnt <= r_cnt + 6'd1;
            OP_MUL_AB,
            OP_MUL_RB: begin
                if (mul_done) begin
                    r_res <= mul_res;
                end
            end
            OP_MUL_BB: begin
                if (mul_done) begin
                    r_base <= mul_res;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_out_data.result <= r_res;
            r_out_data.error  <= r_err;
        end
    end

    // no transfer is taken while reset is held
    assign o_in_stall  = !ctl.in_ready || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> tb/m61_alu_checker.sv
// checker for the mod 2^61-1 arithmetic unit: watches both channels, predicts each result
// and compares it with what the unit returns; depends on m61_pkg only
`timescale 1ns / 1ps

module m61_alu_checker import m61_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending
);

    localparam logic [63:0] P64 = {3'b000, M61_P};
    localparam int SHOW_MAX = 10;

    typedef struct {
        t_in_item  src;
        t_out_item want;
    } t_field_op;

    t_field_op awaited_q[$];
    int        n_fail = 0;

    // one fold of the top three bits, then one conditional subtract
    function automatic logic [63:0] fold_mod_p(input logic [63:0] x);
        logic [63:0] y;
        y = {3'b000, x[60:0]} + {61'd0, x[63:61]};
        if (y >= P64) begin
            y = y - P64;
        end
        return y;
    endfunction

    function automatic logic [63:0] mul_mod_p(input logic [63:0] a, input logic [63:0] b);
        logic [121:0] prod;
        prod = 122'(a[60:0]) * 122'(b[60:0]);
        return fold_mod_p({3'b000, prod[121:61]} + {3'b000, prod[60:0]});
    endfunction

    // a^(p-2) by square and multiply over all exponent bits
    function automatic logic [63:0] inv_mod_p(input logic [63:0] a);
        logic [63:0] e;
        logic [63:0] r;
        logic [63:0] base;
        e = P64 - 64'd2;
        r = 64'd1;
        base = a;
        for (int i = 0; i < M61_BITS; i++) begin
            if (e[i]) begin
                r = mul_mod_p(r, base);
            end
            base = mul_mod_p(base, base);
        end
        return r;
    endfunction

    function automatic t_out_item field_op(input t_in_item it);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        t_out_item   o;
        a = fold_mod_p(it.operand_a);
        b = fold_mod_p({3'b000, it.operand_b});
        r = 64'd0;
        o.error = 1'b0;
        case (it.mode)
            MODE_ADD: begin
                r = a + b;
                if (r >= P64) begin
                    r = r - P64;
                end
            end
            MODE_SUB: begin
                r = (a >= b) ? (a - b) : (a + P64 - b);
            end
            MODE_MUL: begin
                r = mul_mod_p(a, b);
            end
            MODE_NEG: begin
                r = (a == 64'd0) ? 64'd0 : (P64 - a);
            end
            MODE_INV: begin
                if (a == 64'd0) begin
                    o.error = 1'b1;
                end else begin
                    r = inv_mod_p(a);
                end
            end
            MODE_RED: begin
                r = fold_mod_p(it.operand_a);
            end
            default: begin
                r = 64'd0;
            end
        endcase
        o.result = r[60:0];
        return o;
    endfunction

    always @(posedge i_clk) begin : watch
        t_field_op head;
        t_field_op entry;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= SHOW_MAX) begin
                        $display("unexpected result %h error %b, nothing outstanding",
                                 i_out_data.result, i_out_data.error);
                    end
                end else begin
                    head = awaited_q.pop_front();
                    if (head.want.result !== i_out_data.result ||
                        head.want.error !== i_out_data.error) begin
                        n_fail++;
                        if (n_fail <= SHOW_MAX) begin
                            $display("mismatch mode %0d a %h b %h: expected %h/%b, got %h/%b",
                                     head.src.mode, head.src.operand_a, head.src.operand_b,
                                     head.want.result, head.want.error,
                                     i_out_data.result, i_out_data.error);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                entry.src = i_in_data;
                entry.want = field_op(i_in_data);
                awaited_q.push_back(entry);
            end
        end
        o_errors <= n_fail;
        o_pending <= awaited_q.size();
    end

endmodule

>>> tb/testbench.sv
// top of the testbench for the mod 2^61-1 arithmetic unit: clock, reset, stimulus, verdict
// depends on m61_pkg, mersenne61_field_alu and m61_alu_checker
`timescale 1ns / 1ps

module testbench;
    import m61_pkg::*;

    localparam logic [2:0]  MODE_RSVD6 = 3'd6;
    localparam logic [2:0]  MODE_RSVD7 = 3'd7;
    localparam logic [63:0] P64 = {3'b000, M61_P};
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_sent = 0;
    int n_mul = 0;
    int n_inv = 0;
    int n_wide = 0;

    int idle_by_phase[4] = '{0, 60, 0, 37};
    int stall_by_phase[4] = '{0, 0, 60, 37};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mersenne61_field_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    m61_alu_checker alu_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_in_item make_op(input logic [2:0] mode, input logic [63:0] a,
                                         input logic [60:0] b);
        t_in_item it;
        it.mode = mode;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    // first operand: extremes, multiples of p, full 64-bit words, field elements
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        case ($urandom_range(0, 11))
            0:       w = 64'd0;
            1:       w = 64'd1;
            2:       w = P64 - 64'd1;
            3:       w = P64;
            4:       w = P64 * 64'($urandom_range(1, 8));
            5:       w = ALL_ONES;
            6, 7:    w = {$urandom, $urandom};
            default: w = {3'b000, 61'({$urandom, $urandom})};
        endcase
        return w;
    endfunction

    function automatic logic [60:0] rand_elem();
        logic [60:0] e;
        case ($urandom_range(0, 19))
            0:       e = 61'd0;
            1:       e = 61'd1;
            2:       e = M61_P - 61'd1;
            3:       e = M61_P;
            default: e = 61'({$urandom, $urandom});
        endcase
        return e;
    endfunction

    // invert is rare since it runs far longer than any other mode
    function automatic t_in_item rand_op();
        logic [2:0] mode;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 18)      mode = MODE_ADD;
        else if (pick < 36) mode = MODE_SUB;
        else if (pick < 56) mode = MODE_MUL;
        else if (pick < 70) mode = MODE_NEG;
        else if (pick < 72) mode = MODE_INV;
        else if (pick < 94) mode = MODE_RED;
        else if (pick < 97) mode = MODE_RSVD6;
        else                mode = MODE_RSVD7;
        return make_op(mode, rand_word(), rand_elem());
    endfunction

    task automatic send_op(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        n_sent++;
        if (it.mode == MODE_MUL) n_mul++;
        if (it.mode == MODE_INV) n_inv++;
        if (it.operand_a >= P64) n_wide++;
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_op(make_op(MODE_ADD, 64'd0, 61'd0));
        send_op(make_op(MODE_ADD, P64 - 64'd1, M61_P - 61'd1));
        send_op(make_op(MODE_ADD, P64 - 64'd1, 61'd1));
        send_op(make_op(MODE_ADD, ALL_ONES, M61_P));
        send_op(make_op(MODE_SUB, 64'd0, 61'd1));
        send_op(make_op(MODE_SUB, 64'd12345, 61'd12345));
        send_op(make_op(MODE_SUB, P64 - 64'd1, 61'd0));
        send_op(make_op(MODE_SUB, P64, M61_P - 61'd1));
        send_op(make_op(MODE_MUL, P64 - 64'd1, M61_P - 61'd1));
        send_op(make_op(MODE_MUL, 64'd0, M61_P - 61'd1));
        send_op(make_op(MODE_MUL, ALL_ONES, M61_P));
        send_op(make_op(MODE_MUL, 64'h1234_5678_9ABC_DEF0, 61'h0FED_CBA9_8765_4321));
        send_op(make_op(MODE_NEG, 64'd0, M61_P - 61'd1));
        send_op(make_op(MODE_NEG, 64'd1, 61'd0));
        send_op(make_op(MODE_NEG, P64, 61'd7));
        send_op(make_op(MODE_INV, 64'd0, 61'd5));
        send_op(make_op(MODE_INV, 64'd1, 61'd0));
        send_op(make_op(MODE_INV, P64 - 64'd1, 61'd0));
        send_op(make_op(MODE_INV, P64 * 64'd2, 61'd3));
        send_op(make_op(MODE_RED, ALL_ONES, M61_P - 61'd1));
        send_op(make_op(MODE_RED, P64, 61'd0));
        send_op(make_op(MODE_RED, P64 - 64'd1, 61'd0));
        send_op(make_op(MODE_RED, 64'd0, 61'd1));
        send_op(make_op(MODE_RSVD6, ALL_ONES, M61_P - 61'd1));
        send_op(make_op(MODE_RSVD7, P64 - 64'd1, 61'd1));
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_op(rand_op());
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d operations: %0d multiply, %0d invert, %0d first operands >= p",
                 n_sent, n_mul, n_inv, n_wide);
        $display("under free flow, sender gaps, result backpressure and both together");
        if (errors == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
